// File: rtl/hdf_pkg.sv
// Shared types, codes and sizes for the half-duplex idle-gap framer.
package hdf_pkg;

	localparam int SEND_DEPTH = 64;
	localparam int RECV_DEPTH = 64;
	localparam int SEND_IDX_W = $clog2(SEND_DEPTH);
	localparam int SEND_CNT_W = $clog2(SEND_DEPTH + 1);
	localparam int RECV_IDX_W = $clog2(RECV_DEPTH);
	localparam int RECV_CNT_W = $clog2(RECV_DEPTH + 1);

	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_RECV  = 3'd1;
	localparam logic [2:0] OP_SENT  = 3'd2;
	localparam logic [2:0] OP_PUSH  = 3'd3;
	localparam logic [2:0] OP_FETCH = 3'd4;

	localparam logic [2:0] LINK_IDLE      = 3'd0;
	localparam logic [2:0] LINK_SENDING   = 3'd1;
	localparam logic [2:0] LINK_SENT      = 3'd2;
	localparam logic [2:0] LINK_RECEIVING = 3'd3;
	localparam logic [2:0] LINK_FRAME     = 3'd4;

	localparam logic [7:0] GAP_RESET = 8'd4;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic       accepted;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       driver_enable;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic [6:0] frame_length;
		logic       last;
		logic [2:0] link_state;
	} out_item_t;

	typedef struct packed {
		logic exec;
		logic emit_tx;
		logic emit_rx;
	} dp_cmd_t;

	typedef struct packed {
		logic tx_follow;
		logic rx_run;
		logic rx_last;
		logic out_free;
	} dp_stat_t;

endpackage

// File: rtl/hdf_ctrl.sv
// Controller state machine: item acceptance and result sequencing.
module hdf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  hdf_pkg::dp_stat_t stat,
	output hdf_pkg::dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_TX   = 3'b010,
		ST_RX   = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = !((state_q == ST_IDLE) && stat.out_free);

	always_comb begin
		state_d     = state_q;
		cmd.exec    = 1'b0;
		cmd.emit_tx = 1'b0;
		cmd.emit_rx = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && stat.out_free) begin
					cmd.exec = 1'b1;
					if (stat.tx_follow) begin
						state_d = ST_TX;
					end else if (stat.rx_run) begin
						state_d = ST_RX;
					end
				end
			end
			ST_TX: begin
				if (stat.out_free) begin
					cmd.emit_tx = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_RX: begin
				if (stat.out_free) begin
					cmd.emit_rx = 1'b1;
					if (stat.rx_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/hdf_datapath.sv
// Datapath: link state, staging and receive memories, output register.
module hdf_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [7:0]        cfg_wdata,
	input  hdf_pkg::in_item_t  in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output hdf_pkg::out_item_t out_item,
	input  hdf_pkg::dp_cmd_t   cmd,
	output hdf_pkg::dp_stat_t  stat
);

	localparam int SIW = hdf_pkg::SEND_IDX_W;
	localparam int SCW = hdf_pkg::SEND_CNT_W;
	localparam int RIW = hdf_pkg::RECV_IDX_W;
	localparam int RCW = hdf_pkg::RECV_CNT_W;

	// Two banks: one collects pushed bytes while the other is being sent.
	logic [7:0] send_mem [2*hdf_pkg::SEND_DEPTH];
	logic [7:0] recv_mem [hdf_pkg::RECV_DEPTH];

	logic [7:0]     gap_q;
	logic [2:0]     mode_q, mode_d;
	logic           drive_q, drive_d;
	logic [SCW-1:0] staged_q, staged_d, staged_after;
	logic           stage_bank_q, send_bank_q, bank_swap;
	logic [7:0]     stage_first_q;
	logic [SCW-1:0] send_total_q, send_total_d;
	logic [SIW-1:0] send_pos_q, send_pos_d;
	logic [SCW-1:0] send_sum;
	logic [RIW-1:0] recv_pos_q, recv_pos_d;
	logic [RCW-1:0] recv_sum;
	logic [RCW-1:0] recv_total_q, recv_total_d;
	logic [7:0]     idle_q, idle_d;
	logic [RIW-1:0] fetch_idx_q;
	logic [RCW-1:0] fetch_len_q;
	logic [7:0]     send_rd_q, recv_rd_q;
	logic           push_room, send_we, recv_we;
	logic           recv_rd_en;
	logic [RIW-1:0] recv_rd_addr;
	logic           tx_follow, rx_run, rx_last, out_free;
	logic           out_valid_q, out_load;
	hdf_pkg::out_item_t out_q, res, load_val;

	assign push_room    = staged_q < SCW'(hdf_pkg::SEND_DEPTH);
	assign staged_after = push_room ? staged_q + SCW'(1) : staged_q;
	assign send_sum     = SCW'(send_pos_q) + SCW'(1);
	assign recv_sum     = RCW'(recv_pos_q) + RCW'(1);

	always_comb begin
		mode_d       = mode_q;
		drive_d      = drive_q;
		staged_d     = staged_q;
		send_total_d = send_total_q;
		send_pos_d   = send_pos_q;
		recv_pos_d   = recv_pos_q;
		recv_total_d = recv_total_q;
		idle_d       = idle_q;
		bank_swap    = 1'b0;
		send_we      = 1'b0;
		recv_we      = 1'b0;
		tx_follow    = 1'b0;
		rx_run       = 1'b0;
		res          = '0;
		res.last     = 1'b1;
		case (in_item.opcode)
			hdf_pkg::OP_TICK: begin
				if (mode_q == hdf_pkg::LINK_RECEIVING) begin
					idle_d = (idle_q == 8'hFF) ? idle_q : idle_q + 8'd1;
					if (idle_d >= gap_q) begin
						recv_total_d = RCW'(recv_pos_q);
						recv_pos_d   = '0;
						mode_d       = hdf_pkg::LINK_FRAME;
					end
				end else if (mode_q == hdf_pkg::LINK_SENT) begin
					drive_d = 1'b0;
					mode_d  = hdf_pkg::LINK_IDLE;
				end
			end
			hdf_pkg::OP_RECV: begin
				if (mode_q != hdf_pkg::LINK_SENDING && mode_q != hdf_pkg::LINK_SENT) begin
					recv_we = 1'b1;
					idle_d  = '0;
					if (recv_sum >= RCW'(hdf_pkg::RECV_DEPTH)) begin
						recv_total_d = RCW'(hdf_pkg::RECV_DEPTH);
						recv_pos_d   = '0;
						mode_d       = hdf_pkg::LINK_FRAME;
					end else begin
						recv_pos_d = recv_sum[RIW-1:0];
						mode_d     = hdf_pkg::LINK_RECEIVING;
					end
				end
			end
			hdf_pkg::OP_SENT: begin
				if (mode_q == hdf_pkg::LINK_SENDING) begin
					send_pos_d = send_sum[SIW-1:0];
					if (send_sum < send_total_q) begin
						tx_follow = 1'b1;
					end else begin
						mode_d = hdf_pkg::LINK_SENT;
					end
				end
			end
			hdf_pkg::OP_PUSH: begin
				send_we  = push_room;
				staged_d = staged_after;
				if (in_item.last_byte) begin
					staged_d = '0;
					if (mode_q == hdf_pkg::LINK_IDLE && staged_after != '0) begin
						bank_swap    = 1'b1;
						send_total_d = staged_after;
						send_pos_d   = '0;
						mode_d       = hdf_pkg::LINK_SENDING;
						drive_d      = 1'b1;
						res.accepted = 1'b1;
						res.tx_valid = 1'b1;
						// Entry zero may be written by this very push.
						res.tx_byte  = (staged_q == '0) ? in_item.data_byte : stage_first_q;
					end
				end
			end
			hdf_pkg::OP_FETCH: begin
				if (mode_q == hdf_pkg::LINK_FRAME) begin
					mode_d = hdf_pkg::LINK_IDLE;
					if (recv_total_q != '0) begin
						rx_run = 1'b1;
					end else begin
						res.accepted = 1'b1;
					end
				end
			end
			default: ;
		endcase
		res.driver_enable = drive_d;
		res.link_state    = mode_d;
	end

	assign rx_last  = (RCW'(fetch_idx_q) + RCW'(1)) == fetch_len_q;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		out_load = 1'b0;
		load_val = res;
		if (cmd.exec && !tx_follow && !rx_run) begin
			out_load = 1'b1;
		end else if (cmd.emit_tx) begin
			out_load               = 1'b1;
			load_val               = '0;
			load_val.tx_valid      = 1'b1;
			load_val.tx_byte       = send_rd_q;
			load_val.driver_enable = drive_q;
			load_val.last          = 1'b1;
			load_val.link_state    = mode_q;
		end else if (cmd.emit_rx) begin
			out_load               = 1'b1;
			load_val               = '0;
			load_val.accepted      = 1'b1;
			load_val.rx_valid      = 1'b1;
			load_val.rx_byte       = recv_rd_q;
			load_val.frame_length  = 7'(fetch_len_q);
			load_val.last          = rx_last;
			load_val.driver_enable = drive_q;
			load_val.link_state    = mode_q;
		end
	end

	always_comb begin
		recv_rd_en   = 1'b0;
		recv_rd_addr = '0;
		if (cmd.exec && rx_run) begin
			recv_rd_en = 1'b1;
		end else if (cmd.emit_rx) begin
			recv_rd_en   = 1'b1;
			recv_rd_addr = fetch_idx_q + RIW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q        <= hdf_pkg::GAP_RESET;
			mode_q       <= hdf_pkg::LINK_IDLE;
			drive_q      <= 1'b0;
			staged_q     <= '0;
			stage_bank_q <= 1'b0;
			send_bank_q  <= 1'b0;
			send_total_q <= '0;
			send_pos_q   <= '0;
			recv_pos_q   <= '0;
			recv_total_q <= '0;
			idle_q       <= '0;
			fetch_idx_q  <= '0;
			fetch_len_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				gap_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				mode_q       <= mode_d;
				drive_q      <= drive_d;
				staged_q     <= staged_d;
				send_total_q <= send_total_d;
				send_pos_q   <= send_pos_d;
				recv_pos_q   <= recv_pos_d;
				recv_total_q <= recv_total_d;
				idle_q       <= idle_d;
				if (bank_swap) begin
					send_bank_q  <= stage_bank_q;
					stage_bank_q <= !stage_bank_q;
				end
				if (rx_run) begin
					fetch_idx_q <= '0;
					fetch_len_q <= recv_total_q;
				end
			end else if (cmd.emit_rx) begin
				fetch_idx_q <= fetch_idx_q + RIW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && send_we) begin
			send_mem[{stage_bank_q, staged_q[SIW-1:0]}] <= in_item.data_byte;
			if (staged_q == '0) begin
				stage_first_q <= in_item.data_byte;
			end
		end
		if (cmd.exec && tx_follow) begin
			send_rd_q <= send_mem[{send_bank_q, send_sum[SIW-1:0]}];
		end
		if (cmd.exec && recv_we) begin
			recv_mem[recv_pos_q] <= in_item.data_byte;
		end
		if (recv_rd_en) begin
			recv_rd_q <= recv_mem[recv_rd_addr];
		end
		if (out_load) begin
			out_q <= load_val;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_item       = out_q;
	assign stat.tx_follow = tx_follow;
	assign stat.rx_run    = rx_run;
	assign stat.rx_last   = rx_last;
	assign stat.out_free  = out_free;

endmodule

// File: rtl/half_duplex_idle_gap_framer.sv
// A single-result item shows its result in the cycle after acceptance.
// A byte-sent item that emits a stored byte reads it into a read register first.
// A fetch reads its first byte likewise, then shows one byte per cycle unless stalled.
// Throughput: one item per cycle while the output is free; a stored-byte emit
// or a fetch holds off new items until done; each store's read port paces them.
// Reset (arst_n low) clears link control state; the byte stores are not cleared.
module half_duplex_idle_gap_framer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  hdf_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output hdf_pkg::out_item_t out_item,
	input  logic               cfg_write,
	input  logic [7:0]         cfg_wdata
);

	hdf_pkg::dp_cmd_t  cmd;
	hdf_pkg::dp_stat_t stat;

	hdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	hdf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_wdata (cfg_wdata),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// File: rtl/hdf_checker.sv
// Port-level checker for the framer and its bind statement.
module hdf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input hdf_pkg::out_item_t out_item
);

	// A stalled result holds until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// A waiting result blocks new items.
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("item accepted while result stalled");

	a_tx_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.tx_valid |-> out_item.driver_enable)
		else $error("transmit byte without driver enabled");

	// Only bytes of a fetched frame may leave a run open.
	a_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.rx_valid |-> out_item.last)
		else $error("open run on a non-fetch result");

	a_rx_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.rx_valid |-> out_item.accepted && out_item.frame_length != 7'd0)
		else $error("fetched byte without a frame");

endmodule

bind half_duplex_idle_gap_framer hdf_checker u_hdf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

// File: tb/half_duplex_idle_gap_framer_test.sv
// Self-checking testbench for the half-duplex idle-gap framer with an item-level predictor.
module half_duplex_idle_gap_framer_test;
	timeunit 1ns;
	timeprecision 1ps;
	import hdf_pkg::*;

	// Opcodes the block must treat as no-ops.
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int LONG_HOLD_CYCLES = 300;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_item_t   in_item = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_item_t  out_item;
	logic       cfg_write = 1'b0;
	logic [7:0] cfg_wdata = '0;

	half_duplex_idle_gap_framer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_write (cfg_write),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Predicted framer state, starting from its reset values.
	logic [7:0] gap_limit = GAP_RESET;
	logic [2:0] link_now = LINK_IDLE;
	logic       drive_on = 1'b0;
	logic [7:0] tx_stage [SEND_DEPTH] = '{default: '0};
	logic [7:0] tx_frame [SEND_DEPTH] = '{default: '0};
	logic [6:0] stage_fill = '0;
	logic [6:0] tx_len = '0;
	logic [7:0] tx_pos = '0;
	logic [7:0] rx_frame [RECV_DEPTH] = '{default: '0};
	logic [6:0] rx_fill = '0;
	logic [6:0] rx_len = '0;
	logic [7:0] quiet_ticks = '0;

	out_item_t  awaited_results [$];
	in_item_t   item_backlog [$];
	out_item_t  want_item;
	int         items_accepted = 0;
	int         items_queued = 0;
	int         mismatch_count = 0;
	int         send_gap_max = 0;
	int         recv_gap_max = 0;
	int         send_wait = 0;
	int         recv_wait = 0;
	int         hold_asks = 0;
	int         hold_served = 0;
	int         hold_left = 0;
	logic       offer;

	function automatic out_item_t framer_result(logic acc, logic txv, logic [7:0] txb,
			logic rxv, logic [7:0] rxb, logic [6:0] len, logic lst);
		out_item_t r;
		r.accepted = acc;
		r.tx_valid = txv;
		r.tx_byte = txb;
		r.driver_enable = drive_on;
		r.rx_valid = rxv;
		r.rx_byte = rxb;
		r.frame_length = len;
		r.last = lst;
		r.link_state = link_now;
		return r;
	endfunction

	task automatic advance_framer(in_item_t it);
		logic [6:0] n;
		logic       emitted;
		emitted = 1'b0;
		case (it.opcode)
		OP_TICK: begin
			if (link_now == LINK_RECEIVING) begin
				if (quiet_ticks != 8'hFF)
					quiet_ticks = quiet_ticks + 8'd1;
				if (quiet_ticks >= gap_limit) begin
					rx_len = rx_fill;
					rx_fill = '0;
					link_now = LINK_FRAME;
				end
			end
			if (link_now == LINK_SENT) begin
				drive_on = 1'b0;
				link_now = LINK_IDLE;
			end
		end
		OP_RECV: begin
			// The line belongs to us while a frame is going out.
			if (link_now != LINK_SENDING && link_now != LINK_SENT) begin
				rx_frame[rx_fill[RECV_IDX_W-1:0]] = it.data_byte;
				rx_fill = rx_fill + 7'd1;
				quiet_ticks = '0;
				if (rx_fill >= RECV_DEPTH) begin
					rx_len = 7'(RECV_DEPTH);
					rx_fill = '0;
					link_now = LINK_FRAME;
				end else begin
					link_now = LINK_RECEIVING;
				end
			end
		end
		OP_SENT: begin
			if (link_now == LINK_SENDING) begin
				tx_pos = tx_pos + 8'd1;
				if (tx_pos < tx_len && tx_pos < SEND_DEPTH) begin
					awaited_results.push_back(framer_result(1'b0, 1'b1,
						tx_frame[tx_pos[SEND_IDX_W-1:0]], 1'b0, 8'd0, 7'd0, 1'b1));
					emitted = 1'b1;
				end else begin
					link_now = LINK_SENT;
				end
			end
		end
		OP_PUSH: begin
			if (stage_fill < SEND_DEPTH) begin
				tx_stage[stage_fill[SEND_IDX_W-1:0]] = it.data_byte;
				stage_fill = stage_fill + 7'd1;
			end
			if (it.last_byte) begin
				n = stage_fill;
				stage_fill = '0;
				if (link_now == LINK_IDLE && n != 0) begin
					tx_frame = tx_stage;
					tx_len = n;
					tx_pos = '0;
					link_now = LINK_SENDING;
					drive_on = 1'b1;
					awaited_results.push_back(framer_result(1'b1, 1'b1, tx_frame[0],
						1'b0, 8'd0, 7'd0, 1'b1));
					emitted = 1'b1;
				end
			end
		end
		OP_FETCH: begin
			if (link_now == LINK_FRAME) begin
				link_now = LINK_IDLE;
				for (int i = 0; i < rx_len; i++)
					awaited_results.push_back(framer_result(1'b1, 1'b0, 8'd0, 1'b1,
						rx_frame[RECV_IDX_W'(i)], rx_len, i == rx_len - 1));
				if (rx_len == 0)
					awaited_results.push_back(framer_result(1'b1, 1'b0, 8'd0, 1'b0, 8'd0,
						7'd0, 1'b1));
				emitted = 1'b1;
			end
		end
		default: ;
		endcase
		if (!emitted)
			awaited_results.push_back(framer_result(1'b0, 1'b0, 8'd0, 1'b0, 8'd0, 7'd0, 1'b1));
	endtask

	task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s: expected %h, got %h", $time, what, want, got);
	endtask

	// Sender: offers backlog items, with a random gap before each one.
	always @(posedge clk) begin
		if (arst_n) begin
			offer = in_valid;
			if (in_valid && !in_stall) begin
				advance_framer(in_item);
				items_accepted++;
				offer = 1'b0;
				send_wait = $urandom_range(0, send_gap_max);
			end
			if (!offer) begin
				if (send_wait != 0) begin
					send_wait--;
				end else if (item_backlog.size() != 0) begin
					in_item <= item_backlog.pop_front();
					offer = 1'b1;
				end
			end
			in_valid <= offer;
		end
	end

	// Long receiver hold-off, counted here and seen by the receiver in the following cycle.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_asks) begin
			hold_left <= LONG_HOLD_CYCLES;
			hold_served <= hold_asks;
		end
	end

	// Receiver: checks each result and stalls at random after it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					note_mismatch("unexpected result", '0, 32'(out_item));
				end else begin
					want_item = awaited_results.pop_front();
					if (out_item.accepted !== want_item.accepted)
						note_mismatch("accepted", 32'(want_item.accepted),
							32'(out_item.accepted));
					if (out_item.tx_valid !== want_item.tx_valid)
						note_mismatch("tx_valid", 32'(want_item.tx_valid),
							32'(out_item.tx_valid));
					if (out_item.tx_byte !== want_item.tx_byte)
						note_mismatch("tx_byte", 32'(want_item.tx_byte), 32'(out_item.tx_byte));
					if (out_item.driver_enable !== want_item.driver_enable)
						note_mismatch("driver_enable", 32'(want_item.driver_enable),
							32'(out_item.driver_enable));
					if (out_item.rx_valid !== want_item.rx_valid)
						note_mismatch("rx_valid", 32'(want_item.rx_valid),
							32'(out_item.rx_valid));
					if (out_item.rx_byte !== want_item.rx_byte)
						note_mismatch("rx_byte", 32'(want_item.rx_byte), 32'(out_item.rx_byte));
					if (out_item.frame_length !== want_item.frame_length)
						note_mismatch("frame_length", 32'(want_item.frame_length),
							32'(out_item.frame_length));
					if (out_item.last !== want_item.last)
						note_mismatch("last", 32'(want_item.last), 32'(out_item.last));
					if (out_item.link_state !== want_item.link_state)
						note_mismatch("link_state", 32'(want_item.link_state),
							32'(out_item.link_state));
				end
				recv_wait = $urandom_range(0, recv_gap_max);
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
			end else if (recv_wait != 0) begin
				recv_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic queue_item(logic [2:0] op, logic [7:0] data, logic fin);
		in_item_t it;
		it.opcode = op;
		it.data_byte = data;
		it.last_byte = fin;
		item_backlog.push_back(it);
		items_queued++;
	endtask

	task automatic queue_tick();
		queue_item(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	// A received frame with short silences inside it, the closing gap, then a fetch.
	task automatic queue_rx_frame(int len);
		for (int i = 0; i < len; i++) begin
			queue_item(OP_RECV, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			if (gap_limit > 1 && $urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, gap_limit - 1)) queue_tick();
		end
		repeat (gap_limit == 0 ? 1 : gap_limit) queue_tick();
		queue_item(OP_FETCH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	// A frame to send: the pushes, one byte-sent report per stored byte, then a tick to release.
	task automatic queue_tx_frame(int len);
		for (int i = 0; i < len; i++)
			queue_item(OP_PUSH, 8'($urandom_range(0, 255)), i == len - 1);
		repeat (len > SEND_DEPTH ? SEND_DEPTH : len)
			queue_item(OP_SENT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		queue_tick();
	endtask

	task automatic wait_quiet();
		while (items_accepted != items_queued || awaited_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_gap(logic [7:0] v);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		gap_limit = v;
	endtask

	task automatic set_pace(int s, int r);
		send_gap_max <= s;
		recv_gap_max <= r;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		set_pace(12, 12);
		@(posedge clk);

		// Directed items with the reset gap of four ticks.
		queue_item(OP_FETCH, 8'h00, 1'b0);
		queue_item(OP_SPARE_LO, 8'hFF, 1'b1);
		queue_item(OP_SENT, 8'h00, 1'b0);
		queue_item(OP_TICK, 8'hFF, 1'b1);
		queue_item(OP_RECV, 8'h00, 1'b0);
		queue_item(OP_TICK, 8'h00, 1'b0);
		queue_item(OP_RECV, 8'hFF, 1'b1);
		repeat (4) queue_item(OP_TICK, 8'h00, 1'b0);
		// A byte after the frame closed throws the stored frame away.
		queue_item(OP_RECV, 8'h3C, 1'b0);
		repeat (4) queue_item(OP_TICK, 8'h00, 1'b0);
		queue_item(OP_FETCH, 8'h00, 1'b0);
		queue_item(OP_PUSH, 8'hA5, 1'b0);
		queue_item(OP_PUSH, 8'h5A, 1'b1);
		queue_item(OP_RECV, 8'h77, 1'b0);
		queue_item(OP_PUSH, 8'h11, 1'b1);
		queue_item(OP_SENT, 8'h00, 1'b0);
		queue_item(OP_SENT, 8'h00, 1'b0);
		queue_item(OP_RECV, 8'h88, 1'b1);
		queue_item(OP_TICK, 8'h00, 1'b0);
		wait_quiet();

		set_gap(8'd1);
		set_pace(0, 0);
		queue_rx_frame(3);
		queue_tx_frame(2);
		queue_rx_frame(1);
		wait_quiet();

		// With a gap of zero any tick closes the frame.
		set_gap(8'd0);
		set_pace(3, 3);
		queue_tick();
		queue_rx_frame(3);
		wait_quiet();

		// Fill the receive buffer while the output is held off, so the input backs up.
		set_gap(8'd2);
		hold_asks <= hold_asks + 1;
		set_pace(0, 4);
		queue_rx_frame(RECV_DEPTH);
		queue_tx_frame(5);
		wait_quiet();

		while (items_queued < 180) begin
			if ($urandom_range(0, 4) == 0) begin
				wait_quiet();
				set_gap(8'($urandom_range(1, 6)));
				set_pace($urandom_range(0, 1) ? 12 : 0, $urandom_range(0, 1) ? 12 : 0);
			end
			case ($urandom_range(0, 9))
			0, 1, 2, 3:
				queue_rx_frame($urandom_range(0, 15) == 0 ? $urandom_range(9, RECV_DEPTH)
					: $urandom_range(1, 8));
			4, 5, 6:
				queue_tx_frame($urandom_range(0, 15) == 0 ? $urandom_range(9, SEND_DEPTH + 6)
					: $urandom_range(1, 8));
			default:
				repeat ($urandom_range(1, 4))
					queue_item(3'($urandom_range(0, OP_SPARE_HI)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
			endcase
		end
		wait_quiet();

		if (mismatch_count == 0)
			$display("half_duplex_idle_gap_framer test passed");
		else
			$display("half_duplex_idle_gap_framer test failed");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("half_duplex_idle_gap_framer test failed");
		$finish;
	end

endmodule
